>>> rtl/amicable_pair_checker_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the amicable pair checker
// Wraps concurrent assertions so that synthesis sees empty bodies.
// ----------------------------------------------------------------------------
`ifndef AMICABLE_PAIR_CHECKER_TOP_MACROS_SVH
`define AMICABLE_PAIR_CHECKER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is held.
`define APC_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("apc assertion failed");

// Next-cycle implication, disabled while reset is held.
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("apc assertion failed");

`else

`define APC_ASSERT(label, clk, rst_n, ante, cons)
`define APC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/apc_pkg.sv
// ----------------------------------------------------------------------------
// Amicable pair checker package
// Item types, microcode encoding and the microprogram itself.
// ----------------------------------------------------------------------------
package apc_pkg;

    localparam int NUMBER_WIDTH  = 31;
    localparam int SUM_WIDTH     = 35;
    localparam int DIV_CNT_WIDTH = $clog2(NUMBER_WIDTH);
    localparam int PC_WIDTH      = 4;
    localparam int OP_WIDTH      = 4;
    localparam int COND_WIDTH    = 3;

    typedef struct packed {
        logic [NUMBER_WIDTH-1:0] first_number;
        logic [NUMBER_WIDTH-1:0] second_number;
    } t_in_item;

    typedef struct packed {
        logic                 is_amicable;
        logic [SUM_WIDTH-1:0] first_divisor_sum;
        logic [SUM_WIDTH-1:0] second_divisor_sum;
    } t_out_item;

    // Datapath operations.
    localparam logic [OP_WIDTH-1:0] OP_NOP      = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_ACCEPT   = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_START    = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV_INIT = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_DIV_STEP = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_ADD_D    = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_ADD_Q    = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_STORE    = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_EMIT     = 4'd8;

    // Jump conditions.
    localparam logic [COND_WIDTH-1:0] COND_NEVER    = 3'd0;
    localparam logic [COND_WIDTH-1:0] COND_ALWAYS   = 3'd1;
    localparam logic [COND_WIDTH-1:0] COND_NO_INPUT = 3'd2;
    localparam logic [COND_WIDTH-1:0] COND_DIV_MORE = 3'd3;
    localparam logic [COND_WIDTH-1:0] COND_D_GT_Q   = 3'd4;
    localparam logic [COND_WIDTH-1:0] COND_FIRST    = 3'd5;
    localparam logic [COND_WIDTH-1:0] COND_OUT_BUSY = 3'd6;

    // Program addresses.
    localparam logic [PC_WIDTH-1:0] STEP_ACCEPT   = 4'd0;
    localparam logic [PC_WIDTH-1:0] STEP_START    = 4'd1;
    localparam logic [PC_WIDTH-1:0] STEP_DIV_INIT = 4'd2;
    localparam logic [PC_WIDTH-1:0] STEP_DIV      = 4'd3;
    localparam logic [PC_WIDTH-1:0] STEP_TEST     = 4'd4;
    localparam logic [PC_WIDTH-1:0] STEP_ADD_D    = 4'd5;
    localparam logic [PC_WIDTH-1:0] STEP_ADD_Q    = 4'd6;
    localparam logic [PC_WIDTH-1:0] STEP_STORE    = 4'd7;
    localparam logic [PC_WIDTH-1:0] STEP_EMIT     = 4'd8;
    localparam logic [PC_WIDTH-1:0] STEP_RETURN   = 4'd9;
    localparam logic [PC_WIDTH-1:0] STEP_LAST     = STEP_RETURN;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [COND_WIDTH-1:0] cond;
        logic [PC_WIDTH-1:0]   target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic div_more;
        logic d_gt_q;
        logic first;
        logic out_busy;
    } t_dp_status;

    // The microprogram. A jump is taken when its condition holds, otherwise
    // the step counter moves on by one.
    function automatic t_uword uprog(input logic [PC_WIDTH-1:0] pc);
        t_uword w;
        unique case (pc)
            STEP_ACCEPT:   w = '{OP_ACCEPT,   COND_NO_INPUT, STEP_ACCEPT};
            STEP_START:    w = '{OP_START,    COND_NEVER,    STEP_ACCEPT};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEVER,    STEP_ACCEPT};
            STEP_DIV:      w = '{OP_DIV_STEP, COND_DIV_MORE, STEP_DIV};
            STEP_TEST:     w = '{OP_NOP,      COND_D_GT_Q,   STEP_STORE};
            STEP_ADD_D:    w = '{OP_ADD_D,    COND_NEVER,    STEP_ACCEPT};
            STEP_ADD_Q:    w = '{OP_ADD_Q,    COND_ALWAYS,   STEP_DIV_INIT};
            STEP_STORE:    w = '{OP_STORE,    COND_FIRST,    STEP_DIV_INIT};
            STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_BUSY, STEP_EMIT};
            STEP_RETURN:   w = '{OP_NOP,      COND_ALWAYS,   STEP_ACCEPT};
            default:       w = '{OP_NOP,      COND_ALWAYS,   STEP_ACCEPT};
        endcase
        return w;
    endfunction

endpackage

>>> rtl/amicable_pair_checker_top.sv
// ----------------------------------------------------------------------------
// Amicable pair checker
// Microcoded test of whether two numbers form an amicable pair.
// ----------------------------------------------------------------------------
// The block takes an item of two numbers and returns one item holding the sum
// of the proper divisors of each and a flag that is set when each sum equals
// the other number; equal perfect numbers, and the pair of zeros, also set
// the flag. The divisor sums come from trial division by d = 1, 2, ... for as
// long as d does not exceed n / d, and each trial runs through a shared
// restoring divider that produces one quotient bit per cycle. A trial that
// continues runs through set-up, the divider steps, a test and two accumulate
// steps, and the final trial ends with its test; the divider loop dominates
// the time an item takes. Items are handled one at a time, and the input is
// ready only while the sequencer waits at its accept step. The result sits in
// an output register, so a finished item waiting there does not stop the next
// one from being accepted and worked on; the block only stalls at the end of
// that next item if the earlier result has still not been taken. Sums saturate
// at all ones, which a 31-bit input cannot reach.
module amicable_pair_checker_top
    import apc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    `include "amicable_pair_checker_top_macros.svh"

    // Step counter and the control word that the microprogram holds for it.
    logic [PC_WIDTH-1:0] r_pc, n_pc;
    t_uword              uword;
    t_dp_status          dp_status;
    logic                jump;

    assign uword = uprog(r_pc);

    // Each control word names one condition; a taken jump loads the target,
    // otherwise the sequencer falls through to the next step.
    always_comb begin
        unique case (uword.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !dp_status.in_valid;
            COND_DIV_MORE: jump = dp_status.div_more;
            COND_D_GT_Q:   jump = dp_status.d_gt_q;
            COND_FIRST:    jump = dp_status.first;
            COND_OUT_BUSY: jump = dp_status.out_busy;
            default:       jump = 1'b1;
        endcase
        n_pc = jump ? uword.target : (r_pc + PC_WIDTH'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= STEP_ACCEPT;
        end else begin
            r_pc <= n_pc;
        end
    end

    // The datapath carries out whichever operation the current word selects.
    apc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (uword.op),
        .o_status    (dp_status),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // An accepted item always starts the first number's pass next.
    `APC_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_pc == STEP_START)
    // A new result appears only from the emit step.
    `APC_ASSERT(a_emit_source, i_clk, i_rst_n, $rose(o_out_valid), $past(r_pc) == STEP_EMIT)
    // The step counter never leaves the program.
    `APC_ASSERT(a_pc_range, i_clk, i_rst_n, 1'b1, r_pc <= STEP_LAST)
    // The divider keeps the sequencer at its step until every bit is done.
    `APC_ASSERT_NEXT(a_div_loop, i_clk, i_rst_n, r_pc == STEP_DIV && dp_status.div_more, r_pc == STEP_DIV)

endmodule

>>> rtl/apc_datapath.sv
// ----------------------------------------------------------------------------
// Amicable pair checker datapath
// Operand registers, bit-serial divider, saturating accumulator and the
// output register, all steered by the microcode operation.
// ----------------------------------------------------------------------------
module apc_datapath
    import apc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [OP_WIDTH-1:0] i_op,
    output t_dp_status          o_status,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_item            i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_item
);

    localparam int NW = NUMBER_WIDTH;
    localparam int SW = SUM_WIDTH;

    logic [NW-1:0]            r_a, n_a;
    logic [NW-1:0]            r_b, n_b;
    logic [NW-1:0]            r_n, n_n;
    logic [NW-1:0]            r_d, n_d;
    logic [NW-1:0]            r_q, n_q;
    logic [NW-1:0]            r_r, n_r;
    logic [DIV_CNT_WIDTH-1:0] r_cnt, n_cnt;
    logic [SW-1:0]            r_acc, n_acc;
    logic [SW-1:0]            r_sum_a, n_sum_a;
    logic [SW-1:0]            r_sum_b, n_sum_b;
    logic                     r_sel, n_sel;
    logic                     r_out_valid, n_out_valid;
    t_out_item                r_out_item, n_out_item;

    logic [NW:0]   div_shift;
    logic [NW:0]   div_diff;
    logic          rem_zero;
    logic          add_en;
    logic [NW-1:0] addend;
    logic [SW:0]   add_sum;
    logic [SW-1:0] acc_sat;
    logic          out_busy;

    assign out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        div_shift = {r_r, r_q[NW-1]};
        div_diff  = div_shift - {1'b0, r_d};
        rem_zero  = (r_r == '0);
        addend    = (i_op == OP_ADD_Q) ? r_q : r_d;
        add_en    = (i_op == OP_ADD_Q) ? (rem_zero && r_q != r_d && r_q != r_n)
                                       : (rem_zero && r_d != r_n);
        add_sum   = {1'b0, r_acc} + (SW+1)'(addend);
        acc_sat   = add_sum[SW] ? '1 : add_sum[SW-1:0];
    end

    always_comb begin
        n_a         = r_a;
        n_b         = r_b;
        n_n         = r_n;
        n_d         = r_d;
        n_q         = r_q;
        n_r         = r_r;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_sum_a     = r_sum_a;
        n_sum_b     = r_sum_b;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_item  = r_out_item;
        unique case (i_op)
            OP_ACCEPT: begin
                if (i_in_valid) begin
                    n_a = i_in_item.first_number;
                    n_b = i_in_item.second_number;
                end
            end
            OP_START: begin
                n_n   = r_a;
                n_acc = '0;
                n_d   = NW'(1);
                n_sel = 1'b0;
            end
            OP_DIV_INIT: begin
                n_r   = '0;
                n_q   = r_n;
                n_cnt = DIV_CNT_WIDTH'(NW - 1);
            end
            OP_DIV_STEP: begin
                // One restoring division step per cycle.
                if (!div_diff[NW]) begin
                    n_r = div_diff[NW-1:0];
                    n_q = {r_q[NW-2:0], 1'b1};
                end else begin
                    n_r = div_shift[NW-1:0];
                    n_q = {r_q[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt - DIV_CNT_WIDTH'(1);
            end
            OP_ADD_D: begin
                if (add_en) begin
                    n_acc = acc_sat;
                end
            end
            OP_ADD_Q: begin
                if (add_en) begin
                    n_acc = acc_sat;
                end
                n_d = r_d + NW'(1);
            end
            OP_STORE: begin
                if (!r_sel) begin
                    n_sum_a = r_acc;
                    n_n     = r_b;
                    n_acc   = '0;
                    n_d     = NW'(1);
                    n_sel   = 1'b1;
                end else begin
                    n_sum_b = r_acc;
                end
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    n_out_valid                   = 1'b1;
                    n_out_item.is_amicable        = (r_sum_a == SW'(r_b)) &&
                                                    (r_sum_b == SW'(r_a));
                    n_out_item.first_divisor_sum  = r_sum_a;
                    n_out_item.second_divisor_sum = r_sum_b;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a        <= n_a;
        r_b        <= n_b;
        r_n        <= n_n;
        r_d        <= n_d;
        r_q        <= n_q;
        r_r        <= n_r;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_sum_a    <= n_sum_a;
        r_sum_b    <= n_sum_b;
        r_sel      <= n_sel;
        r_out_item <= n_out_item;
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready = (i_op == OP_ACCEPT);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign o_status = '{
        in_valid: i_in_valid,
        div_more: (r_cnt != '0),
        d_gt_q:   (r_d > r_q),
        first:    !r_sel,
        out_busy: out_busy
    };

endmodule
